[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh - assertion helpers for the MT19937 word generator
// Assertions are compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// clocked property, disabled while reset is low
`define MTW_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("mtw assertion failed");
// condition that must never hold
`define MTW_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("mtw forbidden condition seen");
`else
`define MTW_ASSERT(lbl, clk, rstn, prop)
`define MTW_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

[rtl/mtw_pkg.sv]
// ---------------------------------------------------------------------------
// mtw_pkg - shared types, constants and functions
// Twist and temper functions, controller state, command and status structs.
// ---------------------------------------------------------------------------
package mtw_pkg;

    localparam int WORD_W          = 32;
    localparam int FUNC_W          = 2;
    localparam int STATE_DEPTH_DEF = 624;
    localparam int TAP_OFFSET_DEF  = 397;

    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [WORD_W-1:0] SEED_RESET   = 32'd5489;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_RAW      = 2'd0,
        FUNC_SIGNED   = 2'd1,
        FUNC_INTERVAL = 2'd2,
        FUNC_RAW_ALT  = 2'd3
    } mtw_func_t;

    typedef enum logic [2:0] {
        ST_FILL_SEED,
        ST_FILL_MUL,
        ST_FILL_ADD,
        ST_IDLE,
        ST_TWIST,
        ST_MODW,
        ST_OUTW
    } mtw_state_t;

    typedef struct packed {
        logic fill_seed;     // write seed to word 0, restart fill
        logic fill_mul;      // seeding multiply
        logic fill_add;      // add index, write next seed word
        logic take_req;      // latch request fields
        logic twist;         // twist current word, write back, advance index
        logic mod_start;     // start interval remainder
        logic load_direct;   // output register from twist path
        logic load_hold;     // output register from hold registers
    } mtw_cmd_t;

    typedef struct packed {
        logic fill_last;     // last seed word being written
        logic interval;      // latched request is interval mode
        logic mod_done;      // remainder ready in hold register next cycle
    } mtw_stat_t;

    function automatic logic [WORD_W-1:0] mt_twist(input logic [WORD_W-1:0] cur,
                                                   input logic [WORD_W-1:0] nxt,
                                                   input logic [WORD_W-1:0] tap);
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] r;
        y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
        r = tap ^ (y >> 1);
        if (y[0]) begin
            r = r ^ TWIST_MATRIX;
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] mt_temper(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

[rtl/mt19937_word_generator.sv]
// ---------------------------------------------------------------------------
// mt19937_word_generator - MT19937 tempered word generator, top level
// Request stream in, one 64-bit result per request out, seed config port.
// ---------------------------------------------------------------------------
// s_* carries a request: s_tuser = func, s_tdata = bounds for interval mode.
// m_* returns {value, word} for each request, in request order.
// cfg_* writes the seed; cfg_ready is always high. Write only when idle.
// Reset and seed write refill the state RAM: word 0 first, then each
// further word by a multiply, then an add and write, with s_tready low
// throughout. Reset seed is 5489.
// Each request twists one state word; the three reads come from three RAM
// copies. Raw and signed requests pass the accept and twist states; the
// twist state loads the output register, raising m_tvalid, when it is free.
// Interval requests run the bit-serial remainder before their result
// goes out; a zero span skips the divide. No new request is taken until
// the result has left the hold register.
// While m_tready is low the output register holds its result and one more
// request is taken; its result waits in a hold register with s_tready low.
// ---------------------------------------------------------------------------
module mt19937_word_generator #(
    parameter int STATE_DEPTH = mtw_pkg::STATE_DEPTH_DEF,
    parameter int TAP_OFFSET  = mtw_pkg::TAP_OFFSET_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // seed write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mtw_pkg::WORD_W-1:0]    cfg_data,
    // request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [2*mtw_pkg::WORD_W-1:0]  s_tdata,   // [31:0] low_bound, [63:32] high_bound
    input  logic [mtw_pkg::FUNC_W-1:0]    s_tuser,   // [1:0] func
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [2*mtw_pkg::WORD_W-1:0]  m_tdata    // [31:0] word, [63:32] value
);
    import mtw_pkg::*;

    mtw_cmd_t          cmd;
    mtw_stat_t         stat;
    logic [WORD_W-1:0] res_word;
    logic [WORD_W-1:0] res_value;

    // seed register always takes a write
    assign cfg_ready = 1'b1;

    mtw_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    mtw_datapath #(
        .STATE_DEPTH (STATE_DEPTH),
        .TAP_OFFSET  (TAP_OFFSET)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .req_func  (s_tuser),
        .req_low   (s_tdata[WORD_W-1:0]),
        .req_high  (s_tdata[2*WORD_W-1:WORD_W]),
        .res_word  (res_word),
        .res_value (res_value)
    );

    assign m_tdata = {res_value, res_word};

endmodule

[rtl/mtw_ram.sv]
// ---------------------------------------------------------------------------
// mtw_ram - generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module mtw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/mtw_mod.sv]
// ---------------------------------------------------------------------------
// mtw_mod - iterative 32-bit remainder
// Restoring remainder, one dividend bit per cycle; divisor 0 means 2^32.
// ---------------------------------------------------------------------------
module mtw_mod (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [mtw_pkg::WORD_W-1:0] dividend,
    input  logic [mtw_pkg::WORD_W-1:0] divisor,
    output logic                      done,
    output logic [mtw_pkg::WORD_W-1:0] rem
);
    import mtw_pkg::*;

    localparam int CW = $clog2(WORD_W);
    localparam logic [CW-1:0] LAST_STEP = CW'(WORD_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [WORD_W-1:0] dvd_reg, dvd_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;

    assign trial = {rem_reg, dvd_reg[WORD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start) begin
            dvd_next = dividend;
            dvs_next = divisor;
            cnt_next = '0;
            if (divisor == '0) begin
                // full range: remainder is the word itself
                rem_next  = dividend;
                done_next = 1'b1;
            end else begin
                rem_next  = '0;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            rem_next = diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

[rtl/mtw_datapath.sv]
// ---------------------------------------------------------------------------
// mtw_datapath - state memory, seeding, twist, temper and result registers
// Three copies of the state RAM give the three reads a twist needs.
// ---------------------------------------------------------------------------
module mtw_datapath #(
    parameter int STATE_DEPTH = mtw_pkg::STATE_DEPTH_DEF,
    parameter int TAP_OFFSET  = mtw_pkg::TAP_OFFSET_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  mtw_pkg::mtw_cmd_t          cmd,
    output mtw_pkg::mtw_stat_t         stat,
    input  logic                       cfg_valid,
    input  logic [mtw_pkg::WORD_W-1:0] cfg_data,
    input  logic [mtw_pkg::FUNC_W-1:0] req_func,
    input  logic [mtw_pkg::WORD_W-1:0] req_low,
    input  logic [mtw_pkg::WORD_W-1:0] req_high,
    output logic [mtw_pkg::WORD_W-1:0] res_word,
    output logic [mtw_pkg::WORD_W-1:0] res_value
);
    import mtw_pkg::*;

    localparam int AW = $clog2(STATE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(STATE_DEPTH - 1);
    localparam logic [AW-1:0] TAP      = AW'(TAP_OFFSET);
    localparam logic [AW-1:0] WRAP     = AW'(STATE_DEPTH - TAP_OFFSET);

    logic [WORD_W-1:0] seed_reg;
    logic [AW-1:0]     fidx_reg;
    logic [WORD_W-1:0] prev_reg;
    logic [WORD_W-1:0] prod_reg;
    logic [AW-1:0]     widx_reg;
    mtw_func_t         func_reg;
    logic [WORD_W-1:0] low_reg;
    logic [WORD_W-1:0] span_reg;
    logic [WORD_W-1:0] word_hold_reg;
    logic [WORD_W-1:0] val_hold_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic [WORD_W-1:0] out_val_reg;

    logic [AW-1:0]     a_cur, a_nxt, a_tap;
    logic [WORD_W-1:0] rd_cur, rd_nxt, rd_tap;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] fill_word;
    logic [WORD_W-1:0] twisted;
    logic [WORD_W-1:0] word_c;
    logic [WORD_W-1:0] value_c;
    logic [WORD_W-1:0] mag;
    logic              mod_done;
    logic [WORD_W-1:0] mod_rem;

    // read addresses: i, i+1 and i+TAP, all mod depth
    assign a_cur = widx_reg;
    assign a_nxt = (widx_reg == LAST_IDX) ? '0 : widx_reg + 1'b1;
    assign a_tap = (widx_reg < WRAP) ? widx_reg + TAP : widx_reg - WRAP;

    assign fill_word = prod_reg + WORD_W'(fidx_reg);
    assign twisted   = mt_twist(rd_cur, rd_nxt, rd_tap);
    assign word_c    = mt_temper(twisted);
    assign mag       = word_c & LOW_BITS;

    always_comb begin
        case (func_reg)
            FUNC_SIGNED: value_c = word_c[WORD_W-1] ? (~mag + 1'b1) : mag;
            default:     value_c = word_c;
        endcase
    end

    assign ram_we    = cmd.fill_seed | cmd.fill_add | cmd.twist;
    assign ram_waddr = cmd.twist ? widx_reg : (cmd.fill_seed ? '0 : fidx_reg);
    assign ram_wdata = cmd.twist ? twisted : (cmd.fill_seed ? seed_reg : fill_word);

    mtw_ram #(.WIDTH(WORD_W), .DEPTH(STATE_DEPTH)) u_ram_cur (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(a_cur), .rdata(rd_cur)
    );

    mtw_ram #(.WIDTH(WORD_W), .DEPTH(STATE_DEPTH)) u_ram_nxt (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(a_nxt), .rdata(rd_nxt)
    );

    mtw_ram #(.WIDTH(WORD_W), .DEPTH(STATE_DEPTH)) u_ram_tap (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(a_tap), .rdata(rd_tap)
    );

    mtw_mod u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.mod_start),
        .dividend (word_c),
        .divisor  (span_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= SEED_RESET;
        end else if (cfg_valid) begin
            seed_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fill_seed) begin
            fidx_reg <= AW'(1);
            prev_reg <= seed_reg;
            widx_reg <= '0;
        end else begin
            if (cmd.fill_add) begin
                fidx_reg <= fidx_reg + 1'b1;
                prev_reg <= fill_word;
            end
            if (cmd.twist) begin
                widx_reg <= a_nxt;
            end
        end
        if (cmd.fill_mul) begin
            prod_reg <= SEED_MULT * (prev_reg ^ (prev_reg >> 30));
        end
        if (cmd.take_req) begin
            func_reg <= mtw_func_t'(req_func);
            low_reg  <= req_low;
            span_reg <= req_high - req_low + 1'b1;
        end
        if (cmd.twist) begin
            word_hold_reg <= word_c;
            val_hold_reg  <= value_c;
        end else if (mod_done) begin
            val_hold_reg  <= mod_rem + low_reg;
        end
        if (cmd.load_direct) begin
            out_word_reg <= word_c;
            out_val_reg  <= value_c;
        end else if (cmd.load_hold) begin
            out_word_reg <= word_hold_reg;
            out_val_reg  <= val_hold_reg;
        end
    end

    assign stat.fill_last = (fidx_reg == LAST_IDX);
    assign stat.interval  = (func_reg == FUNC_INTERVAL);
    assign stat.mod_done  = mod_done;

    assign res_word  = out_word_reg;
    assign res_value = out_val_reg;

endmodule

[rtl/mtw_ctrl.sv]
// ---------------------------------------------------------------------------
// mtw_ctrl - sequencing of state fill, requests and output register
// Drives datapath commands; owns the output valid flag.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mtw_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output mtw_pkg::mtw_cmd_t  cmd,
    input  mtw_pkg::mtw_stat_t stat
);
    import mtw_pkg::*;

    mtw_state_t state_reg, state_next;
    logic       mvalid_reg, mvalid_next;
    logic       out_free;

    assign out_free = !mvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        if (cfg_valid) begin
            state_next = ST_FILL_SEED;
        end else begin
            case (state_reg)
                ST_FILL_SEED: state_next = ST_FILL_MUL;
                ST_FILL_MUL:  state_next = ST_FILL_ADD;
                ST_FILL_ADD:  state_next = stat.fill_last ? ST_IDLE : ST_FILL_MUL;
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_next = ST_TWIST;
                    end
                end
                ST_TWIST: begin
                    if (stat.interval) begin
                        state_next = ST_MODW;
                    end else begin
                        state_next = out_free ? ST_IDLE : ST_OUTW;
                    end
                end
                ST_MODW: begin
                    if (stat.mod_done) begin
                        state_next = ST_OUTW;
                    end
                end
                ST_OUTW: begin
                    if (out_free) begin
                        state_next = ST_IDLE;
                    end
                end
                default: state_next = ST_FILL_SEED;
            endcase
        end
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_FILL_SEED: cmd.fill_seed = 1'b1;
            ST_FILL_MUL:  cmd.fill_mul  = 1'b1;
            ST_FILL_ADD:  cmd.fill_add  = 1'b1;
            ST_IDLE: begin
                s_tready     = !cfg_valid;
                cmd.take_req = s_tvalid && !cfg_valid;
            end
            ST_TWIST: begin
                cmd.twist       = 1'b1;
                cmd.mod_start   = stat.interval;
                cmd.load_direct = !stat.interval && out_free;
            end
            ST_OUTW: cmd.load_hold = out_free;
            default: cmd = '0;
        endcase
    end

    assign mvalid_next = (cmd.load_direct || cmd.load_hold) ? 1'b1
                       : (m_tready ? 1'b0 : mvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_FILL_SEED;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;

    `MTW_ASSERT(a_twist_after_accept, aclk, aresetn, state_reg == ST_TWIST |-> $past(s_tvalid && s_tready))
    `MTW_ASSERT_NEVER(a_no_overwrite, aclk, aresetn, (cmd.load_direct || cmd.load_hold) && !out_free)
    `MTW_ASSERT(a_outw_holds, aclk, aresetn, (state_reg == ST_OUTW && !out_free && !cfg_valid) |=> state_reg == ST_OUTW)

endmodule

[test/mt19937_word_generator_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// mt19937_word_generator_tb - self-checking bench for the MT19937 generator
// Drives requests in raw, sign-magnitude and interval modes and rewrites the
// seed between phases. Every returned word and value is checked against a
// bench-side twister that runs in request order. Both stream sides idle in
// random bursts. One phase holds the result side off long enough to back the
// block up into its request port.
// ---------------------------------------------------------------------------
module mt19937_word_generator_tb;
    import mtw_pkg::*;

    typedef logic [WORD_W-1:0] word_t;

    // Field order matches m_tdata: word in [31:0], value in [63:32].
    typedef struct packed {
        word_t value;
        word_t word;
    } gen_result_t;

    localparam word_t S32_MIN       = 32'h8000_0000;
    localparam word_t S32_MAX       = 32'h7fff_ffff;
    localparam int    DRAIN_CYCLES  = 64;     // longer than the interval path
    localparam int    LONG_HOLD     = 400;    // result-side hold-off in the stall phase
    localparam int    RANDOM_ITEMS  = 1100;
    localparam int    RESEED_AT     = 700;    // past one full twist of the state
    localparam int    QUIET_ITEMS   = 150;    // tail of the run with no idling

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    word_t                  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [2*WORD_W-1:0]    s_tdata   = '0;    // [31:0] low_bound, [63:32] high_bound
    logic [FUNC_W-1:0]      s_tuser   = '0;    // [1:0] func
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [2*WORD_W-1:0]    m_tdata;           // [31:0] word, [63:32] value

    // Bench copy of the generator state
    word_t          mt_state [STATE_DEPTH_DEF];
    int unsigned    mt_index;

    gen_result_t    pending_results [$];
    int unsigned    mismatch_count   = 0;
    bit             src_gaps_on      = 1'b0;
    bit             sink_gaps_on     = 1'b0;
    int unsigned    sink_hold_cycles = 0;

    mt19937_word_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Twister model
    // ------------------------------------------------------------------

    // Seeding recurrence; index parked at the end so the next draw twists.
    function automatic void reseed_model(word_t seed);
        word_t prev;
        mt_state[0] = seed;
        for (int i = 1; i < STATE_DEPTH_DEF; i++) begin
            prev        = mt_state[i-1];
            mt_state[i] = SEED_MULT * (prev ^ (prev >> 30)) + word_t'(i);
        end
        mt_index = STATE_DEPTH_DEF;
    endfunction

    // Whole-state twist; the block twists word by word, same sequence.
    function automatic void twist_model();
        word_t mix;
        word_t nxt;
        for (int k = 0; k < STATE_DEPTH_DEF; k++) begin
            mix = (mt_state[k] & HIGH_BIT) | (mt_state[(k + 1) % STATE_DEPTH_DEF] & LOW_BITS);
            nxt = mt_state[(k + TAP_OFFSET_DEF) % STATE_DEPTH_DEF] ^ (mix >> 1);
            if (mix[0]) begin
                nxt = nxt ^ TWIST_MATRIX;
            end
            mt_state[k] = nxt;
        end
        mt_index = 0;
    endfunction

    function automatic word_t draw_word();
        word_t t;
        if (mt_index >= STATE_DEPTH_DEF) begin
            twist_model();
        end
        t = mt_state[mt_index];
        mt_index++;
        t = t ^ (t >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

    function automatic gen_result_t predict_result(mtw_func_t fn, word_t lo, word_t hi);
        gen_result_t r;
        word_t       span;
        r.word = draw_word();
        span   = hi - lo + 32'd1;        // zero here stands for 2^32
        case (fn)
            FUNC_SIGNED: begin
                // sign-magnitude; 0x80000000 folds to zero
                r.value = r.word[31] ? -{1'b0, r.word[30:0]} : {1'b0, r.word[30:0]};
            end
            FUNC_INTERVAL: begin
                r.value = ((span == '0) ? r.word : r.word % span) + lo;
            end
            default: begin
                r.value = r.word;        // raw, and the spare code acts as raw
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic mtw_func_t random_func();
        case ($urandom_range(0, 9))
            0, 1, 2: return FUNC_RAW;
            3, 4, 5: return FUNC_SIGNED;
            6, 7, 8: return FUNC_INTERVAL;
            default: return FUNC_RAW_ALT;
        endcase
    endfunction

    // Bounds biased toward narrow, power-of-two, full and wrapped spans.
    task automatic random_bounds(output word_t lo, output word_t hi);
        lo = $urandom;
        case ($urandom_range(0, 4))
            0:       hi = $urandom;
            1:       hi = lo + $urandom_range(0, 15);
            2:       hi = lo + ((word_t'(1) << $urandom_range(1, 31)) - 32'd1);
            3:       hi = lo - 32'd1;                     // full range, zero span
            default: hi = lo - $urandom_range(2, 64);     // inverted, span near 2^32
        endcase
    endtask

    // One request; the expectation is queued at the accepting edge.
    task automatic send_request(mtw_func_t fn, word_t lo, word_t hi);
        int unsigned gap;
        s_tuser  <= fn;
        s_tdata  <= {hi, lo};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_result(fn, lo, hi));
        if (src_gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Seed writes only happen with nothing in flight.
    task automatic write_seed(word_t seed);
        cfg_data  <= seed;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reseed_model(seed);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always begin
        @(posedge aclk);
        if (sink_hold_cycles != 0) begin
            m_tready <= 1'b0;
            repeat (sink_hold_cycles) @(posedge aclk);
            sink_hold_cycles = 0;
            m_tready <= 1'b1;
        end else if (sink_gaps_on && $urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic void log_mismatch(string what, word_t want, word_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] mismatch on %s: expected %08h, got %08h", $realtime, what, want, got);
        end
    endfunction

    // Compare each accepted result against the oldest outstanding request.
    always @(posedge aclk) begin : result_check
        gen_result_t got;
        gen_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = gen_result_t'(m_tdata);
            if (pending_results.size() == 0) begin
                log_mismatch("unrequested result word", '0, got.word);
            end else begin
                want = pending_results.pop_front();
                if (got.word !== want.word) begin
                    log_mismatch("word", want.word, got.word);
                end
                if (got.value !== want.value) begin
                    log_mismatch("value", want.value, got.value);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Default seed straight out of reset: every func code and bound corner.
    task automatic test_reset_seed_directed();
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        reseed_model(SEED_RESET);
        send_request(FUNC_RAW,      '0,      '0);
        send_request(FUNC_RAW,      '1,      '1);
        send_request(FUNC_RAW_ALT,  S32_MIN, S32_MAX);
        send_request(FUNC_RAW_ALT,  '1,      '0);
        send_request(FUNC_SIGNED,   '0,      '1);
        send_request(FUNC_SIGNED,   '1,      '0);
        send_request(FUNC_SIGNED,   S32_MAX, S32_MIN);
        send_request(FUNC_SIGNED,   S32_MIN, S32_MAX);
        send_request(FUNC_INTERVAL, S32_MIN, S32_MAX);         // full range
        send_request(FUNC_INTERVAL, 32'd5,   32'd4);           // full range, small bounds
        send_request(FUNC_INTERVAL, '0,      '1);              // 0 .. -1 wraps to full
        send_request(FUNC_INTERVAL, '0,      '0);              // single value
        send_request(FUNC_INTERVAL, S32_MAX, S32_MAX);
        send_request(FUNC_INTERVAL, S32_MIN, S32_MIN);
        send_request(FUNC_INTERVAL, 32'd100, word_t'(-100));   // inverted bounds
        send_request(FUNC_INTERVAL, S32_MAX, S32_MIN);         // wraps to span 2
        send_request(FUNC_INTERVAL, '1,      '0);
        send_request(FUNC_INTERVAL, word_t'(-1000), 32'd1000);
        send_request(FUNC_INTERVAL, '0,      S32_MAX);
        send_request(FUNC_INTERVAL, S32_MIN, '1);
        end_burst();
        wait_drained();
    endtask

    // Seed register at its extremes and at the top bit alone.
    task automatic test_seed_extremes();
        word_t seed_list [3];
        word_t lo;
        word_t hi;
        seed_list = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000};
        foreach (seed_list[s]) begin
            write_seed(seed_list[s]);
            for (int n = 0; n < 40; n++) begin
                random_bounds(lo, hi);
                send_request(random_func(), lo, hi);
            end
            end_burst();
            wait_drained();
        end
    endtask

    // Result side held off while requests keep coming: the block must
    // hold its output, back up and drop s_tready without losing anything.
    task automatic test_output_stall();
        word_t lo;
        word_t hi;
        src_gaps_on      = 1'b0;
        sink_gaps_on     = 1'b0;
        sink_hold_cycles = LONG_HOLD;
        for (int n = 0; n < 32; n++) begin
            random_bounds(lo, hi);
            send_request((n % 8 == 7) ? FUNC_INTERVAL : FUNC_SIGNED, lo, hi);
        end
        end_burst();
        wait_drained();
    endtask

    // Bulk random traffic across a twist boundary and a mid-run reseed.
    task automatic test_random_traffic();
        word_t     lo;
        word_t     hi;
        mtw_func_t fn;
        write_seed(word_t'($urandom));
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RESEED_AT) begin
                end_burst();
                wait_drained();
                write_seed(word_t'($urandom));
            end
            // alternate idle and busy stretches; the tail runs flat out
            src_gaps_on  = (n < RANDOM_ITEMS - QUIET_ITEMS) && ((n / 128) % 2 == 0);
            sink_gaps_on = (n < RANDOM_ITEMS - QUIET_ITEMS) && ((n / 96) % 3 != 2);
            fn = random_func();
            random_bounds(lo, hi);
            send_request(fn, lo, hi);
        end
        end_burst();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_seed_directed();
        test_seed_extremes();
        test_output_stall();
        test_random_traffic();
        wait_drained();
        if (mismatch_count == 0) begin
            $display("PASS mt19937_word_generator");
        end else begin
            $display("FAIL mt19937_word_generator");
        end
        $finish;
    end

    // Watchdog, well past the slowest legal run
    initial begin
        #4_000_000;
        $display("FAIL mt19937_word_generator");
        $finish;
    end

endmodule
